// ===== hw/rtl/tower_shadow_test_unit_macros.svh =====
// Assertion macros shared by the tower shadow test RTL
`ifndef TOWER_SHADOW_TEST_UNIT_MACROS_SVH
`define TOWER_SHADOW_TEST_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define TSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tower shadow check failed");
// condition in one cycle implies a result in the next
`define TSU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tower shadow sequence check failed");
`else
`define TSU_ASSERT(lbl, prop)
`define TSU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/tsu_pkg.sv =====
// Shared types and constants of the tower shadow test unit
package tsu_pkg;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  typedef logic [1:0] status_t;

  // result status codes
  localparam status_t ST_HIT    = 2'd0;
  localparam status_t ST_MISS   = 2'd1;
  localparam status_t ST_ZENITH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

endpackage

// ===== hw/rtl/tsu_if.sv =====
// Channel interfaces: query input, result output, register write
interface tsu_in_if #(parameter int PW = 24, parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] helio_x;
  logic signed [PW-1:0] helio_y;
  logic signed [PW-1:0] helio_z;
  logic signed [DW-1:0] sun_x;
  logic signed [DW-1:0] sun_y;
  logic signed [DW-1:0] sun_z;
  modport source (output valid, helio_x, helio_y, helio_z, sun_x, sun_y, sun_z,
                  input ready);
  modport sink (input valid, helio_x, helio_y, helio_z, sun_x, sun_y, sun_z,
                output ready);
endinterface

interface tsu_out_if;
  logic       valid;
  logic       ready;
  logic       shaded;
  logic [1:0] hit_status;
  modport source (output valid, shaded, hit_status, input ready);
  modport sink (input valid, shaded, hit_status, output ready);
endinterface

interface tsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  addr;
  logic [23:0] wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== hw/rtl/tower_shadow_test_unit.sv =====
// Top level: pipelined ray against tower cylinder shadow test
//
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   helio_x/y/z, sun_x/y/z
//  out_chan  out  valid/ready   shaded, hit_status
//  cfg_chan  in   valid/ready   addr (0 radius, 1 height), wdata
//
// One query enters per cycle unless a stall backs up to the input; the square-root
// array computes one result bit per stage.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up under a stall and nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and both registers.
`include "tower_shadow_test_unit_macros.svh"
module tower_shadow_test_unit
  import tsu_pkg::*;
#(
  parameter int POS_WIDTH = 24,
  parameter int DIR_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  tsu_in_if.sink   in_chan,
  tsu_out_if.source out_chan,
  tsu_cfg_if.sink  cfg_chan
);

  localparam int PW   = POS_WIDTH;
  localparam int DW   = DIR_WIDTH;
  localparam int XSW  = PW + DW;
  localparam int BW   = XSW + 2;
  localparam int BMW  = BW - 1;
  localparam int AW   = 2 * DW;
  localparam int R2W  = 2 * CFG_W;
  localparam int EW   = ((2 * PW > R2W) ? 2 * PW : R2W) + 1;
  localparam int BL   = BMW / 2;
  localparam int BH   = BMW - BL;
  localparam int EL   = EW / 2;
  localparam int EH   = EW - EL;
  localparam int AEW  = AW + EW + 1;
  localparam int DDW  = ((2 * BMW > AEW + 2) ? 2 * BMW : AEW + 2) + 1;
  localparam int QW   = DDW / 2;
  localparam int RW   = QW + 3;
  localparam int KW   = ((BW > QW + 1) ? BW : QW + 1) + 1;
  localparam int ZAW  = PW + AW + 2;
  localparam int SKW  = DW + KW;
  localparam int TW   = CFG_W + AW + 1;
  localparam int NW   = ((ZAW > SKW) ? ZAW : SKW) + 1;
  localparam int CW   = ((NW > TW) ? NW : TW) + 1;
  localparam int NST  = QW + 8;
  localparam int IR1  = QW + 4;
  localparam int IR2  = QW + 5;
  localparam int IR3  = QW + 6;
  localparam int IOUT = QW + 7;

  // configuration registers
  logic [CFG_W-1:0] radius_r, height_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      height_r <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.addr)
        REG_RADIUS: radius_r <= cfg_chan.wdata;
        REG_HEIGHT: height_r <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  // valid bits and load chain
  logic [NST-1:0] v_r;
  logic [NST:0]   ld;
  logic [NST-1:0] vin;

  assign ld[NST] = out_chan.ready;
  assign vin     = {v_r[NST-2:0], in_chan.valid};

  for (genvar k = 0; k < NST; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (ld[k]) v_r[k] <= vin[k];
      end
    end
  end

  assign in_chan.ready = ld[0];

  // stage 1: products of the inputs
  logic signed [XSW-1:0]  s1_xs_r, s1_ys_r;
  logic [AW-1:0]          s1_sx2_r, s1_sy2_r;
  logic [2*PW-1:0]        s1_x2_r, s1_y2_r;
  logic [R2W-1:0]         s1_r2_r;
  logic signed [PW-1:0]   s1_z_r;
  logic signed [DW-1:0]   s1_sz_r;
  logic signed [2*DW-1:0] sx2_s, sy2_s;
  logic signed [2*PW-1:0] x2_s, y2_s;

  always_comb begin
    sx2_s = in_chan.sun_x * in_chan.sun_x;
    sy2_s = in_chan.sun_y * in_chan.sun_y;
    x2_s  = in_chan.helio_x * in_chan.helio_x;
    y2_s  = in_chan.helio_y * in_chan.helio_y;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_xs_r  <= XSW'(in_chan.helio_x * in_chan.sun_x);
      s1_ys_r  <= XSW'(in_chan.helio_y * in_chan.sun_y);
      s1_sx2_r <= $unsigned(sx2_s);
      s1_sy2_r <= $unsigned(sy2_s);
      s1_x2_r  <= $unsigned(x2_s);
      s1_y2_r  <= $unsigned(y2_s);
      s1_r2_r  <= radius_r * radius_r;
      s1_z_r   <= in_chan.helio_z;
      s1_sz_r  <= in_chan.sun_z;
    end
  end

  // stage 2: A, B and r^2 - (x^2 + y^2)
  logic signed [BW-1:0]  s2_bi_r;
  logic [AW-1:0]         s2_ai_r;
  logic signed [EW-1:0]  s2_e_r;
  logic signed [PW-1:0]  s2_z_r;
  logic signed [DW-1:0]  s2_sz_r;
  logic signed [XSW:0]   bsum;
  logic [2*PW-1:0]       psum;

  always_comb begin
    bsum = {s1_xs_r[XSW-1], s1_xs_r} + {s1_ys_r[XSW-1], s1_ys_r};
    psum = s1_x2_r + s1_y2_r;
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_bi_r <= {bsum, 1'b0};
      s2_ai_r <= s1_sx2_r + s1_sy2_r;
      s2_e_r  <= $signed({{(EW-R2W){1'b0}}, s1_r2_r}) -
                 $signed({{(EW-2*PW){1'b0}}, psum});
      s2_z_r  <= s1_z_r;
      s2_sz_r <= s1_sz_r;
    end
  end

  // stage 3: split products for B^2 and A*(r^2 - p)
  logic [BL+BMW-1:0]          s3_bbl_r;
  logic [BH+BMW-1:0]          s3_bbh_r;
  logic [AW+EL-1:0]           s3_ael_r;
  logic signed [AW+EH:0]      s3_aeh_r;
  logic signed [BW-1:0]       s3_bi_r;
  logic [AW-1:0]              s3_ai_r;
  logic signed [PW-1:0]       s3_z_r;
  logic signed [DW-1:0]       s3_sz_r;
  status_t                    s3_st_r;
  logic [BW-1:0]              bneg;
  logic [BMW-1:0]             bm;

  always_comb begin
    bneg = BW'(0) - $unsigned(s2_bi_r);
    bm   = s2_bi_r[BW-1] ? bneg[BMW-1:0] : s2_bi_r[BMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_bbl_r <= bm[BL-1:0] * bm;
      s3_bbh_r <= bm[BMW-1:BL] * bm;
      s3_ael_r <= s2_ai_r * s2_e_r[EL-1:0];
      s3_aeh_r <= $signed({1'b0, s2_ai_r}) * $signed(s2_e_r[EW-1:EL]);
      s3_bi_r  <= s2_bi_r;
      s3_ai_r  <= s2_ai_r;
      s3_z_r   <= s2_z_r;
      s3_sz_r  <= s2_sz_r;
      s3_st_r  <= (s2_ai_r == '0) ? ST_ZENITH : ST_HIT;
    end
  end

  // stage 4 and square-root array (entry 0 holds the discriminant)
  logic [RW-1:0]         sq_rem_r  [QW+1];
  logic [QW-1:0]         sq_root_r [QW+1];
  logic [2*QW-1:0]       sq_d_r    [QW+1];
  logic signed [BW-1:0]  sq_bi_r   [QW+1];
  logic [AW-1:0]         sq_ai_r   [QW+1];
  logic signed [PW-1:0]  sq_z_r    [QW+1];
  logic signed [DW-1:0]  sq_sz_r   [QW+1];
  status_t               sq_st_r   [QW+1];

  logic [2*BMW-1:0]      bb;
  logic signed [AEW-1:0] ae;
  logic signed [DDW-1:0] disc;

  always_comb begin
    bb   = {s3_bbh_r, {BL{1'b0}}} + (2*BMW)'(s3_bbl_r);
    ae   = ($signed(AEW'(s3_aeh_r)) <<< EL) + $signed(AEW'({1'b0, s3_ael_r}));
    disc = $signed(DDW'(bb)) + ($signed(DDW'(ae)) <<< 2);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_d_r[0]    <= disc[DDW-1] ? '0 : disc[2*QW-1:0];
      sq_bi_r[0]   <= s3_bi_r;
      sq_ai_r[0]   <= s3_ai_r;
      sq_z_r[0]    <= s3_z_r;
      sq_sz_r[0]   <= s3_sz_r;
      sq_st_r[0]   <= (disc[DDW-1] && s3_st_r == ST_HIT) ? ST_MISS : s3_st_r;
    end
  end

  // one root bit per stage, restoring form
  for (genvar j = 1; j <= QW; j++) begin : g_sqrt
    logic [RW-1:0] remsh, trial;
    logic          ge;

    always_comb begin
      remsh = {sq_rem_r[j-1][RW-3:0], sq_d_r[j-1][2*QW-1:2*QW-2]};
      trial = RW'({sq_root_r[j-1], 2'b01});
      ge    = remsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (ld[3+j]) begin
        sq_rem_r[j]  <= ge ? remsh - trial : remsh;
        sq_root_r[j] <= {sq_root_r[j-1][QW-2:0], ge};
        sq_d_r[j]    <= {sq_d_r[j-1][2*QW-3:0], 2'b00};
        sq_bi_r[j]   <= sq_bi_r[j-1];
        sq_ai_r[j]   <= sq_ai_r[j-1];
        sq_z_r[j]    <= sq_z_r[j-1];
        sq_sz_r[j]   <= sq_sz_r[j-1];
        sq_st_r[j]   <= sq_st_r[j-1];
      end
    end
  end

  // R1: the two root numerators -B +/- sqrt(D)
  logic signed [KW-1:0]  r1_k1_r, r1_k2_r;
  logic [AW:0]           r1_a2_r;
  logic signed [PW-1:0]  r1_z_r;
  logic signed [DW-1:0]  r1_sz_r;
  status_t               r1_st_r;
  logic signed [KW-1:0]  bik, sk;

  always_comb begin
    bik = KW'(sq_bi_r[QW]);
    sk  = $signed(KW'(sq_root_r[QW]));
  end

  always_ff @(posedge clk) begin
    if (ld[IR1]) begin
      r1_k1_r <= sk - bik;
      r1_k2_r <= -bik - sk;
      r1_a2_r <= {sq_ai_r[QW], 1'b0};
      r1_z_r  <= sq_z_r[QW];
      r1_sz_r <= sq_sz_r[QW];
      r1_st_r <= sq_st_r[QW];
    end
  end

  // R2: products of the height test
  logic signed [ZAW-1:0] r2_za_r;
  logic signed [SKW-1:0] r2_p1_r, r2_p2_r;
  logic [TW-1:0]         r2_top_r;
  status_t               r2_st_r;

  always_ff @(posedge clk) begin
    if (ld[IR2]) begin
      r2_za_r  <= r1_z_r * $signed({1'b0, r1_a2_r});
      r2_p1_r  <= r1_sz_r * r1_k1_r;
      r2_p2_r  <= r1_sz_r * r1_k2_r;
      r2_top_r <= height_r * r1_a2_r;
      r2_st_r  <= r1_st_r;
    end
  end

  // R3: scaled root heights
  logic signed [NW-1:0] r3_n1_r, r3_n2_r;
  logic [TW-1:0]        r3_top_r;
  status_t              r3_st_r;

  always_ff @(posedge clk) begin
    if (ld[IR3]) begin
      r3_n1_r  <= NW'(r2_za_r) + NW'(r2_p1_r);
      r3_n2_r  <= NW'(r2_za_r) + NW'(r2_p2_r);
      r3_top_r <= r2_top_r;
      r3_st_r  <= r2_st_r;
    end
  end

  // output register: range compares
  logic         out_shaded_r;
  status_t      out_st_r;
  logic [CW-1:0] topx;
  logic          in1, in2;

  always_comb begin
    topx = CW'(r3_top_r);
    in1  = !r3_n1_r[NW-1] && (CW'($unsigned(r3_n1_r)) <= topx);
    in2  = !r3_n2_r[NW-1] && (CW'($unsigned(r3_n2_r)) <= topx);
  end

  always_ff @(posedge clk) begin
    if (ld[IOUT]) begin
      out_shaded_r <= (r3_st_r == ST_HIT) && (in1 || in2);
      out_st_r     <= r3_st_r;
    end
  end

  assign out_chan.valid      = v_r[IOUT];
  assign out_chan.shaded     = out_shaded_r;
  assign out_chan.hit_status = out_st_r;

  // checks
  `TSU_ASSERT(a_no_shade_unless_hit,
    !(out_chan.valid && out_chan.shaded && out_chan.hit_status != ST_HIT))
  `TSU_ASSERT_NEXT(a_out_held, out_chan.valid && !out_chan.ready, out_chan.valid)
  `TSU_ASSERT(a_stall_only_when_full, in_chan.ready || (v_r[0] && v_r[IOUT]))

endmodule

// ===== bench/tb_tower_shadow_test_unit.sv =====
// Testbench for the tower shadow test unit: directed and random queries against a predictor
`timescale 1ns / 100ps
module tb_tower_shadow_test_unit
  import tsu_pkg::*;
;

  localparam int PW         = 24;
  localparam int DW         = 16;
  localparam int SETTLE     = 60;     // pipeline latency plus margin
  localparam int STALL_LIMIT = 20000; // cycles with no transfer at all

  typedef struct packed {
    logic signed [PW-1:0] helio_x;
    logic signed [PW-1:0] helio_y;
    logic signed [PW-1:0] helio_z;
    logic signed [DW-1:0] sun_x;
    logic signed [DW-1:0] sun_y;
    logic signed [DW-1:0] sun_z;
  } query_t;

  typedef struct packed {
    logic    shaded;
    status_t hit_status;
  } shadow_t;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tsu_in_if #(.PW(PW), .DW(DW)) in_chan();
  tsu_out_if out_chan();
  tsu_cfg_if cfg_chan();

  tower_shadow_test_unit #(.POS_WIDTH(PW), .DIR_WIDTH(DW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  always #6 clk = ~clk;

  // predictor copy of the registers
  logic [CFG_W-1:0] radius_q16;
  logic [CFG_W-1:0] height_q16;

  shadow_t shade_expect[$];
  int      errors = 0;
  int      src_idle = 0;
  int      snk_idle = 0;
  int      quiet_cycles = 0;

  // floor square root of a non-negative value
  function automatic logic [63:0] floor_sqrt(input wide_t v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c  = r | (64'd1 << i);
      sq = 128'(c) * 128'(c);
      if (sq <= $unsigned(v)) r = c;
    end
    return r;
  endfunction

  // root height test, cross-multiplied by 2A
  function automatic logic within_height(input wide_t z, input wide_t sz, input wide_t k,
                                         input wide_t a2);
    wide_t num;
    wide_t top;
    num = z * a2 + sz * k;
    top = $signed({104'd0, height_q16}) * a2;
    return (num >= 0) && (num <= top);
  endfunction

  function automatic shadow_t predict_shadow(input query_t q);
    wide_t   x, y, z, sx, sy, sz, ai, bi, p, d, a2, s, rad;
    shadow_t r;
    x  = q.helio_x;
    y  = q.helio_y;
    z  = q.helio_z;
    sx = q.sun_x;
    sy = q.sun_y;
    sz = q.sun_z;
    rad = $signed({104'd0, radius_q16});
    r.shaded = 1'b0;
    ai = sx * sx + sy * sy;
    if (ai == 0) begin
      r.hit_status = ST_ZENITH;
      return r;
    end
    bi = 2 * (x * sx + y * sy);
    p  = x * x + y * y;
    d  = bi * bi + 4 * ai * rad * rad - 4 * ai * p;
    if (d < 0) begin
      r.hit_status = ST_MISS;
      return r;
    end
    s  = $signed({64'd0, floor_sqrt(d)});
    a2 = 2 * ai;
    r.hit_status = ST_HIT;
    r.shaded = within_height(z, sz, -bi + s, a2) || within_height(z, sz, -bi - s, a2);
    return r;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(99) >= snk_idle);
  end

  // result checker
  always @(posedge clk) begin
    shadow_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (shade_expect.size() == 0) begin
        $display("%0t: unexpected result shaded=%0b status=%0d", $time,
                 out_chan.shaded, out_chan.hit_status);
        errors++;
      end else begin
        want = shade_expect.pop_front();
        if (out_chan.shaded !== want.shaded) begin
          $display("%0t: shaded expected %0b actual %0b", $time, want.shaded,
                   out_chan.shaded);
          errors++;
        end
        if (out_chan.hit_status !== want.hit_status) begin
          $display("%0t: hit_status expected %0d actual %0d", $time, want.hit_status,
                   out_chan.hit_status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one query transfer
  task automatic send_query(input query_t q);
    shadow_t want;
    while ($urandom_range(99) < src_idle) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    want = predict_shadow(q);
    in_chan.helio_x = q.helio_x;
    in_chan.helio_y = q.helio_y;
    in_chan.helio_z = q.helio_z;
    in_chan.sun_x   = q.sun_x;
    in_chan.sun_y   = q.sun_y;
    in_chan.sun_z   = q.sun_z;
    in_chan.valid   = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    shade_expect.push_back(want);
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (shade_expect.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // register write, only with the pipeline empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_chan.addr  = idx;
    cfg_chan.wdata = val;
    cfg_chan.valid = 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    if (idx == REG_RADIUS) radius_q16 = val;
    else radius_q16 = radius_q16;
    if (idx == REG_HEIGHT) height_q16 = val;
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  function automatic query_t make_query(input int px, input int py, input int pz,
                                        input int dx, input int dy, input int dz);
    query_t q;
    q.helio_x = px[PW-1:0];
    q.helio_y = py[PW-1:0];
    q.helio_z = pz[PW-1:0];
    q.sun_x   = dx[DW-1:0];
    q.sun_y   = dy[DW-1:0];
    q.sun_z   = dz[DW-1:0];
    return q;
  endfunction

  // mostly geometry near the tower, some raw bit patterns
  function automatic query_t random_query();
    query_t       q;
    int           span;
    logic [127:0] raw;
    if ($urandom_range(99) < 25) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      q   = raw[$bits(query_t)-1:0];
    end else begin
      span = (radius_q16 == 0) ? 4096 : int'(radius_q16 > 2000000 ? 2000000 : radius_q16) * 3;
      q.helio_x = PW'($signed($urandom_range(2 * span)) - span);
      q.helio_y = PW'($signed($urandom_range(2 * span)) - span);
      q.helio_z = PW'($signed($urandom_range(height_q16 / 2 + 16)) - 8);
      q.sun_x   = DW'($signed($urandom_range(32768)) - 16384);
      q.sun_y   = DW'($signed($urandom_range(32768)) - 16384);
      q.sun_z   = DW'($signed($urandom_range(32768)) - 16384);
      if ($urandom_range(9) == 0) begin
        q.sun_x = '0;
        q.sun_y = '0;
      end
    end
    return q;
  endfunction

  task automatic test_directed();
    write_reg(REG_RADIUS, 24'd2560);
    write_reg(REG_HEIGHT, 24'd25600);
    // zenith, with and without a vertical component
    send_query(make_query(100, 200, 0, 0, 0, 16384));
    send_query(make_query(0, 0, 0, 0, 0, 0));
    // straight at the tower, level and from below
    send_query(make_query(-25600, 0, 256, 16384, 0, 0));
    send_query(make_query(-25600, 0, -256, 11585, 0, 11585));
    // far away, parallel: negative discriminant
    send_query(make_query(-25600, 50000, 256, 16384, 0, 0));
    // tangent: grazing the cylinder side
    send_query(make_query(2560, 0, 256, 0, 16384, 0));
    send_query(make_query(2560, 0, 256, 0, -16384, 300));
    // tower behind the heliostat
    send_query(make_query(25600, 0, 256, 16384, 0, 0));
    // field extremes
    send_query(make_query(-8388608, -8388608, -8388608, -32768, -32768, -32768));
    send_query(make_query(8388607, 8388607, 8388607, 32767, 32767, 32767));
    send_query(make_query(8388607, -8388608, 0, -16384, 16384, -16384));
    send_query(make_query(0, 0, 8388607, 16384, -16384, 16384));
    send_query(make_query(-1, -1, -1, -1, -1, -1));
    // extreme registers
    write_reg(REG_RADIUS, 24'hFFFFFF);
    write_reg(REG_HEIGHT, 24'hFFFFFF);
    send_query(make_query(8388607, 8388607, 0, 32767, -32768, 1));
    send_query(make_query(-8388608, 0, 8388607, 1, 0, -32768));
    send_query(make_query(0, 0, 0, 0, 1, 0));
    write_reg(REG_HEIGHT, 24'd0);
    send_query(make_query(0, 0, 0, 16384, 0, 0));
    send_query(make_query(100, 0, 0, 16384, 0, 0));
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_query(random_query());
      if (n == count / 2) begin
        // hold off until the pipeline has emptied
        while (shade_expect.size() != 0) @(negedge clk);
      end
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    src_idle = s_idle;
    snk_idle = r_idle;
    write_reg(REG_RADIUS, 24'd0);
    write_reg(REG_HEIGHT, 24'd0);
    test_random(100);
    write_reg(REG_RADIUS, 24'($urandom_range(200, 20000)));
    write_reg(REG_HEIGHT, 24'($urandom_range(256, 60000)));
    test_random(200);
    write_reg(REG_RADIUS, 24'hFFFFFF);
    write_reg(REG_HEIGHT, 24'hFFFFFF);
    test_random(150);
  endtask

  initial begin
    in_chan.valid   = 1'b0;
    in_chan.helio_x = '0;
    in_chan.helio_y = '0;
    in_chan.helio_z = '0;
    in_chan.sun_x   = '0;
    in_chan.sun_y   = '0;
    in_chan.sun_z   = '0;
    out_chan.ready  = 1'b0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.addr   = '0;
    cfg_chan.wdata  = '0;
    radius_q16      = '0;
    height_q16      = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    run_phase(12, 87);
    run_phase(87, 12);
    run_phase(0, 0);

    while (shade_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
